>>> hdl/ctp_pkg.sv
// ctp_pkg: shared constants and types for the circle tangent point block
// no dependencies; imported by the interfaces, the cells and the top level

package ctp_pkg;

  localparam int TOL_WIDTH  = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

  // lanes in the square root cells and in the divider cells
  localparam int ROOT_LANES = 2;
  localparam int DIV_LANES  = 4;

  typedef enum logic [1:0] {
    COUNT_NONE = 2'd0,
    COUNT_ONE  = 2'd1,
    COUNT_TWO  = 2'd2
  } tangent_count_t;

endpackage

>>> hdl/ctp_if.sv
// ctp_if: valid/ready channel interfaces for query requests and result requests
// depends on ctp_pkg

interface ctp_query_if
  import ctp_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic        [COORD_WIDTH-2:0] radius;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, center_x, center_y, radius, point_x, point_y,
                  input ready);
  modport sink (input valid, center_x, center_y, radius, point_x, point_y,
                output ready);
endinterface

interface ctp_result_if
  import ctp_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  tangent_count_t                tangent_count;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;

  modport source (output valid, tangent_count, first_x, first_y, second_x, second_y,
                  input ready);
  modport sink (input valid, tangent_count, first_x, first_y, second_x, second_y,
                output ready);
endinterface

>>> hdl/circle_tangent_points.sv
// circle_tangent_points: tangent points from a query point to a circle, fixed point
// depends on ctp_pkg, ctp_if, ctp_mul, ctp_root_cell, ctp_div_cell
//
// one query request per clock is taken while the pipe advances and one result request
// comes out per query, in order. the pipeline is made of five entry stages, a chain of
// COORD_WIDTH+1 square root cells (one result bit each, distance and tangent leg side
// by side), a decision stage, a two stage split multiplier, a sign merge stage, a chain
// of COORD_WIDTH+3 divider cells (one quotient bit each, four coordinates side by side),
// a rounding stage and the output register. the whole pipe moves on one enable: it
// advances whenever the output register is empty or its result is being taken, so full
// throughput is kept as long as the sink takes results. coordinates are raw two's
// complement values with any fraction width; the math is exact on raw values. square
// roots round down, divisions round to nearest with ties away from zero, and the final
// sums saturate. touch_tolerance resets to 1 and is written through cfg_we / cfg_wdata;
// the user must write it only while the block is idle; the block itself does not enforce this.

module circle_tangent_points
  import ctp_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TOL_WIDTH-1:0] cfg_wdata,
  ctp_query_if.sink            query,
  ctp_result_if.source         result
);
  localparam int W    = COORD_WIDTH;
  localparam int R    = W - 1;          // radius width
  localparam int V    = W + 1;          // |point - center| width
  localparam int SW   = 2 * V;          // squared distance width
  localparam int Q    = V;              // square root width
  localparam int R2W  = 2 * R;          // r^2 width
  localparam int RLW  = R + Q;          // r * leg width
  localparam int PAW  = R2W + V;        // r^2 * |v| width
  localparam int PBW  = RLW + V;        // r * leg * |v| width
  localparam int MW   = PBW + 1;        // merged numerator width
  localparam int QB   = W + 3;          // quotient width
  localparam int CMPW = Q + 2;          // distance compare width
  localparam int TW   = QB + 3;         // final sum width

  // lanes of the root chain
  localparam int LANE_DIST = 0;
  localparam int LANE_LEG  = 1;
  // lanes of the divider chain
  localparam int LANE_X1 = 0;
  localparam int LANE_Y1 = 1;
  localparam int LANE_X2 = 2;
  localparam int LANE_Y2 = 3;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic [R-1:0]        r;
  } item_t;

  typedef struct packed {
    item_t           item;
    logic            sx;
    logic            sy;
    logic [V-1:0]    ax;
    logic [V-1:0]    ay;
    logic [R2W-1:0]  r2;
    logic [SW-1:0]   s;
  } root_side_t;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    tangent_count_t      count;
    logic                sx;
    logic                sy;
    logic [SW-1:0]       s;
  } mul_side_t;

  typedef struct packed {
    logic signed [W-1:0]  cx;
    logic signed [W-1:0]  cy;
    logic signed [W-1:0]  px;
    logic signed [W-1:0]  py;
    tangent_count_t       count;
    logic [DIV_LANES-1:0] neg;
  } div_side_t;

  localparam int RSW = $bits(root_side_t);
  localparam int DSW = $bits(div_side_t);

  // tolerance register
  logic [TOL_WIDTH-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // global advance: the pipe moves when the output register is free or drains
  logic vout;
  logic adv;

  assign adv         = !vout || result.ready;
  assign query.ready = adv;

  // stage 0: capture the request
  logic  v0;
  item_t item0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item0.cx <= query.center_x;
      item0.cy <= query.center_y;
      item0.px <= query.point_x;
      item0.py <= query.point_y;
      item0.r  <= query.radius;
    end
  end

  // stage 1: offset from center, split into sign and magnitude
  logic signed [V-1:0] vx;
  logic signed [V-1:0] vy;
  logic                v1;
  item_t               item1;
  logic                sx1;
  logic                sy1;
  logic [V-1:0]        ax1;
  logic [V-1:0]        ay1;

  assign vx = V'(item0.px) - V'(item0.cx);
  assign vy = V'(item0.py) - V'(item0.cy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item1 <= item0;
      sx1   <= vx[V-1];
      sy1   <= vy[V-1];
      ax1   <= vx[V-1] ? V'(-vx) : V'(vx);
      ay1   <= vy[V-1] ? V'(-vy) : V'(vy);
    end
  end

  // stage 2: squares
  logic           v2;
  item_t          item2;
  logic           sx2;
  logic           sy2;
  logic [V-1:0]   ax2;
  logic [V-1:0]   ay2;
  logic [SW-1:0]  sqx2;
  logic [SW-1:0]  sqy2;
  logic [R2W-1:0] r2_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item2 <= item1;
      sx2   <= sx1;
      sy2   <= sy1;
      ax2   <= ax1;
      ay2   <= ay1;
      sqx2  <= SW'(ax1) * SW'(ax1);
      sqy2  <= SW'(ay1) * SW'(ay1);
      r2_2  <= R2W'(item1.r) * R2W'(item1.r);
    end
  end

  // stage 3: squared distance
  logic           v3;
  item_t          item3;
  logic           sx3;
  logic           sy3;
  logic [V-1:0]   ax3;
  logic [V-1:0]   ay3;
  logic [R2W-1:0] r2_3;
  logic [SW-1:0]  s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item3 <= item2;
      sx3   <= sx2;
      sy3   <= sy2;
      ax3   <= ax2;
      ay3   <= ay2;
      r2_3  <= r2_2;
      s3    <= sqx2 + sqy2;
    end
  end

  // stage 4: squared tangent leg, clamped at zero for points inside
  logic       v4;
  root_side_t side4;
  logic [SW-1:0] diff4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side4.item <= item3;
      side4.sx   <= sx3;
      side4.sy   <= sy3;
      side4.ax   <= ax3;
      side4.ay   <= ay3;
      side4.r2   <= r2_3;
      side4.s    <= s3;
      diff4      <= (s3 >= SW'(r2_3)) ? s3 - SW'(r2_3) : '0;
    end
  end

  // root chain: distance and tangent leg, one bit per cell from the top
  logic [Q:0]                          root_v;
  logic [Q:0][ROOT_LANES-1:0][SW-1:0]  root_rem;
  logic [Q:0][ROOT_LANES-1:0][Q-1:0]   root_res;
  logic [Q:0][RSW-1:0]                 root_side;

  assign root_v[0]              = v4;
  assign root_rem[0][LANE_DIST] = side4.s;
  assign root_rem[0][LANE_LEG]  = diff4;
  assign root_res[0]            = '0;
  assign root_side[0]           = side4;

  for (genvar i = 0; i < Q; i++) begin : g_root
    ctp_root_cell #(
      .RW     (SW),
      .QW     (Q),
      .BIT    (Q - 1 - i),
      .SIDE_W (RSW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (root_v[i]),
      .in_rem    (root_rem[i]),
      .in_res    (root_res[i]),
      .in_side   (root_side[i]),
      .out_valid (root_v[i+1]),
      .out_rem   (root_rem[i+1]),
      .out_res   (root_res[i+1]),
      .out_side  (root_side[i+1])
    );
  end

  // stage 5: classify and form r * leg
  root_side_t     rs;
  logic [Q-1:0]   dist_root;
  logic [Q-1:0]   leg;
  logic [CMPW-1:0] d_ext;
  logic [CMPW-1:0] r_ext;
  logic [CMPW-1:0] t_ext;
  logic [CMPW-1:0] gap;
  tangent_count_t count_next;

  assign rs        = root_side_t'(root_side[Q]);
  assign dist_root = root_res[Q][LANE_DIST];
  assign leg       = root_res[Q][LANE_LEG];
  assign d_ext     = CMPW'(dist_root);
  assign r_ext     = CMPW'(rs.item.r);
  assign t_ext     = CMPW'(tol);
  assign gap       = (d_ext >= r_ext) ? d_ext - r_ext : r_ext - d_ext;

  always_comb begin
    priority if (d_ext + t_ext < r_ext) begin
      count_next = COUNT_NONE;
    end else if (gap <= t_ext) begin
      count_next = COUNT_ONE;
    end else begin
      count_next = COUNT_TWO;
    end
  end

  logic           v5;
  mul_side_t      side5;
  logic [V-1:0]   ax5;
  logic [V-1:0]   ay5;
  logic [R2W-1:0] r2_5;
  logic [RLW-1:0] rl5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= root_v[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side5.cx    <= rs.item.cx;
      side5.cy    <= rs.item.cy;
      side5.px    <= rs.item.px;
      side5.py    <= rs.item.py;
      side5.count <= count_next;
      side5.sx    <= rs.sx;
      side5.sy    <= rs.sy;
      side5.s     <= rs.s;
      ax5         <= rs.ax;
      ay5         <= rs.ay;
      r2_5        <= rs.r2;
      rl5         <= RLW'(rs.item.r) * RLW'(leg);
    end
  end

  // stages 6 and 7: the four wide products
  logic [PAW-1:0] prod_a;   // r^2 |vx|
  logic [PAW-1:0] prod_c;   // r^2 |vy|
  logic [PBW-1:0] prod_b;   // r leg |vy|
  logic [PBW-1:0] prod_e;   // r leg |vx|

  ctp_mul #(.WA(R2W), .WB(V)) u_mul_a (.clk(clk), .en(adv), .a(r2_5), .b(ax5), .p(prod_a));
  ctp_mul #(.WA(R2W), .WB(V)) u_mul_c (.clk(clk), .en(adv), .a(r2_5), .b(ay5), .p(prod_c));
  ctp_mul #(.WA(RLW), .WB(V)) u_mul_b (.clk(clk), .en(adv), .a(rl5), .b(ay5), .p(prod_b));
  ctp_mul #(.WA(RLW), .WB(V)) u_mul_e (.clk(clk), .en(adv), .a(rl5), .b(ax5), .p(prod_e));

  logic      v6;
  logic      v7;
  mul_side_t side6;
  mul_side_t side7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side6 <= side5;
      side7 <= side6;
    end
  end

  // stage 8: merge the two signed terms of each coordinate
  logic [DIV_LANES-1:0][MW-1:0] pa;
  logic [DIV_LANES-1:0][MW-1:0] pb;
  logic [DIV_LANES-1:0]         na;
  logic [DIV_LANES-1:0]         nb;
  logic [DIV_LANES-1:0][MW-1:0] mag_next;
  logic [DIV_LANES-1:0]         neg_next;

  always_comb begin
    pa[LANE_X1] = MW'(prod_a);  na[LANE_X1] = side7.sx;
    pb[LANE_X1] = MW'(prod_b);  nb[LANE_X1] = !side7.sy;
    pa[LANE_Y1] = MW'(prod_c);  na[LANE_Y1] = side7.sy;
    pb[LANE_Y1] = MW'(prod_e);  nb[LANE_Y1] = side7.sx;
    pa[LANE_X2] = MW'(prod_a);  na[LANE_X2] = side7.sx;
    pb[LANE_X2] = MW'(prod_b);  nb[LANE_X2] = side7.sy;
    pa[LANE_Y2] = MW'(prod_c);  na[LANE_Y2] = side7.sy;
    pb[LANE_Y2] = MW'(prod_e);  nb[LANE_Y2] = !side7.sx;
    for (int l = 0; l < DIV_LANES; l++) begin
      priority if (na[l] == nb[l]) begin
        mag_next[l] = pa[l] + pb[l];
        neg_next[l] = na[l];
      end else if (pa[l] >= pb[l]) begin
        mag_next[l] = pa[l] - pb[l];
        neg_next[l] = na[l];
      end else begin
        mag_next[l] = pb[l] - pa[l];
        neg_next[l] = nb[l];
      end
    end
  end

  logic                         v8;
  div_side_t                    side8;
  logic [SW-1:0]                s8;
  logic [DIV_LANES-1:0][MW-1:0] mag8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side8.cx    <= side7.cx;
      side8.cy    <= side7.cy;
      side8.px    <= side7.px;
      side8.py    <= side7.py;
      side8.count <= side7.count;
      side8.neg   <= neg_next;
      s8          <= side7.s;
      mag8        <= mag_next;
    end
  end

  // divider chain: each merged numerator over the squared distance
  logic [QB:0]                         div_v;
  logic [QB:0][SW-1:0]                 div_dvs;
  logic [QB:0][DIV_LANES-1:0][MW-1:0]  div_rem;
  logic [QB:0][DIV_LANES-1:0][QB-1:0]  div_quo;
  logic [QB:0][DSW-1:0]                div_side;

  assign div_v[0]    = v8;
  assign div_dvs[0]  = s8;
  assign div_rem[0]  = mag8;
  assign div_quo[0]  = '0;
  assign div_side[0] = side8;

  for (genvar i = 0; i < QB; i++) begin : g_div
    ctp_div_cell #(
      .NW     (MW),
      .DVW    (SW),
      .QW     (QB),
      .BIT    (QB - 1 - i),
      .SIDE_W (DSW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (div_v[i]),
      .in_dvs    (div_dvs[i]),
      .in_rem    (div_rem[i]),
      .in_quo    (div_quo[i]),
      .in_side   (div_side[i]),
      .out_valid (div_v[i+1]),
      .out_dvs   (div_dvs[i+1]),
      .out_rem   (div_rem[i+1]),
      .out_quo   (div_quo[i+1]),
      .out_side  (div_side[i+1])
    );
  end

  // stage 9: round to nearest, halves away from zero
  logic                           v9;
  div_side_t                      side9;
  logic [DIV_LANES-1:0][QB:0]     quo9;
  logic [DIV_LANES-1:0]           rnd;

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      rnd[l] = ((MW+1)'(div_rem[QB][l]) << 1) >= (MW+1)'(div_dvs[QB]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= div_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side9 <= div_side_t'(div_side[QB]);
      for (int l = 0; l < DIV_LANES; l++) begin
        quo9[l] <= (QB+1)'(div_quo[QB][l]) + (QB+1)'(rnd[l]);
      end
    end
  end

  // stage 10: add the center, saturate, select by count
  function automatic logic [W-1:0] sat_coord(input logic [TW-1:0] t);
    logic [TW-W:0] top;
    top = t[TW-1:W-1];
    if (top == '0 || top == '1) begin
      return t[W-1:0];
    end else if (t[TW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic [DIV_LANES-1:0][W-1:0] coord;
  logic [DIV_LANES-1:0][W-1:0] center;

  assign center[LANE_X1] = side9.cx;
  assign center[LANE_Y1] = side9.cy;
  assign center[LANE_X2] = side9.cx;
  assign center[LANE_Y2] = side9.cy;

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      coord[l] = sat_coord(side9.neg[l]
                           ? TW'(signed'(center[l])) - TW'(quo9[l])
                           : TW'(signed'(center[l])) + TW'(quo9[l]));
    end
  end

  tangent_count_t out_count;
  logic [W-1:0]   out_fx;
  logic [W-1:0]   out_fy;
  logic [W-1:0]   out_sx;
  logic [W-1:0]   out_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_count <= side9.count;
      unique case (side9.count)
        COUNT_ONE: begin
          out_fx <= side9.px;
          out_fy <= side9.py;
          out_sx <= '0;
          out_sy <= '0;
        end
        COUNT_TWO: begin
          out_fx <= coord[LANE_X1];
          out_fy <= coord[LANE_Y1];
          out_sx <= coord[LANE_X2];
          out_sy <= coord[LANE_Y2];
        end
        default: begin
          out_fx <= '0;
          out_fy <= '0;
          out_sx <= '0;
          out_sy <= '0;
        end
      endcase
    end
  end

  assign result.valid         = vout;
  assign result.tangent_count = out_count;
  assign result.first_x       = out_fx;
  assign result.first_y       = out_fy;
  assign result.second_x      = out_sx;
  assign result.second_y      = out_sy;

endmodule

>>> hdl/ctp_mul.sv
// ctp_mul: two stage unsigned multiplier built from four half-width partial products
// depends on nothing but its parameters

module ctp_mul #(
  parameter int WA = 62,
  parameter int WB = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);
  localparam int HA = (WA + 1) / 2;
  localparam int HB = (WB + 1) / 2;
  localparam int LA = WA - HA;
  localparam int LB = WB - HB;
  localparam int PW = WA + WB;

  logic [HA+HB-1:0] p_ll;
  logic [HA+LB-1:0] p_lh;
  logic [LA+HB-1:0] p_hl;
  logic [LA+LB-1:0] p_hh;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= (HA+HB)'(a[HA-1:0]) * (HA+HB)'(b[HB-1:0]);
      p_lh <= (HA+LB)'(a[HA-1:0]) * (HA+LB)'(b[WB-1:HB]);
      p_hl <= (LA+HB)'(a[WA-1:HA]) * (LA+HB)'(b[HB-1:0]);
      p_hh <= (LA+LB)'(a[WA-1:HA]) * (LA+LB)'(b[WB-1:HB]);
      p    <= PW'(p_ll) + (PW'(p_lh) << HB) + (PW'(p_hl) << HA)
            + (PW'(p_hh) << (HA + HB));
    end
  end

endmodule

>>> hdl/ctp_root_cell.sv
// ctp_root_cell: one result bit of a two lane integer square root chain
// depends on ctp_pkg

module ctp_root_cell
  import ctp_pkg::*;
#(
  parameter int RW     = 66,
  parameter int QW     = 33,
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [ROOT_LANES-1:0][RW-1:0]    in_rem,
  input  logic [ROOT_LANES-1:0][QW-1:0]    in_res,
  input  logic [SIDE_W-1:0]                in_side,
  output logic                             out_valid,
  output logic [ROOT_LANES-1:0][RW-1:0]    out_rem,
  output logic [ROOT_LANES-1:0][QW-1:0]    out_res,
  output logic [SIDE_W-1:0]                out_side
);
  localparam int TW = RW + 1;

  logic [ROOT_LANES-1:0][TW-1:0] sub;
  logic [ROOT_LANES-1:0]         ge;
  logic [ROOT_LANES-1:0][RW-1:0] rem_next;
  logic [ROOT_LANES-1:0][QW-1:0] res_next;

  // (res + 2^bit)^2 - res^2 = res * 2^(bit+1) + 2^(2*bit)
  always_comb begin
    for (int l = 0; l < ROOT_LANES; l++) begin
      sub[l]      = (TW'(in_res[l]) << (BIT + 1)) + (TW'(1) << (2 * BIT));
      ge[l]       = TW'(in_rem[l]) >= sub[l];
      rem_next[l] = ge[l] ? in_rem[l] - sub[l][RW-1:0] : in_rem[l];
      res_next[l] = in_res[l] | (QW'(ge[l]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_res  <= res_next;
      out_side <= in_side;
    end
  end

endmodule

>>> hdl/ctp_div_cell.sv
// ctp_div_cell: one quotient bit of a four lane restoring divider chain
// depends on ctp_pkg

module ctp_div_cell
  import ctp_pkg::*;
#(
  parameter int NW     = 98,
  parameter int DVW    = 66,
  parameter int QW     = 35,
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [DVW-1:0]                  in_dvs,
  input  logic [DIV_LANES-1:0][NW-1:0]    in_rem,
  input  logic [DIV_LANES-1:0][QW-1:0]    in_quo,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic [DVW-1:0]                  out_dvs,
  output logic [DIV_LANES-1:0][NW-1:0]    out_rem,
  output logic [DIV_LANES-1:0][QW-1:0]    out_quo,
  output logic [SIDE_W-1:0]               out_side
);
  localparam int CW = ((NW > DVW + QW) ? NW : DVW + QW) + 1;

  logic [CW-1:0]                shifted;
  logic [DIV_LANES-1:0]         ge;
  logic [DIV_LANES-1:0][NW-1:0] rem_next;
  logic [DIV_LANES-1:0][QW-1:0] quo_next;

  always_comb begin
    shifted = CW'(in_dvs) << BIT;
    for (int l = 0; l < DIV_LANES; l++) begin
      ge[l]       = CW'(in_rem[l]) >= shifted;
      rem_next[l] = ge[l] ? in_rem[l] - shifted[NW-1:0] : in_rem[l];
      quo_next[l] = in_quo[l] | (QW'(ge[l]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dvs  <= in_dvs;
      out_rem  <= rem_next;
      out_quo  <= quo_next;
      out_side <= in_side;
    end
  end

endmodule

>>> tb/circle_tangent_points_test.sv
// circle_tangent_points_test: self-checking bench for the tangent point pipeline
// depends on ctp_pkg, ctp_if and circle_tangent_points; exact wide-integer predictor

`timescale 1ns / 100ps

module circle_tangent_points_test;
  import ctp_pkg::*;

  localparam int CW = 32;
  localparam int DRAIN_CYCLES = 120;   // a bit over the pipe depth
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef logic [191:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [CW-2:0]        r;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } query_t;

  typedef struct {
    tangent_count_t       cnt;
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
  } tangents_t;

  typedef struct {
    query_t    q;
    bit        typed;   // expectation written out by hand
    tangents_t res;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [TOL_WIDTH-1:0] cfg_wdata;

  ctp_query_if  #(.COORD_WIDTH(CW)) query ();
  ctp_result_if #(.COORD_WIDTH(CW)) result ();

  circle_tangent_points #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .query(query), .result(result)
  );

  // predictor copy of the tolerance register
  logic [TOL_WIDTH-1:0] tol_model;
  tangents_t expected_tangents[$];
  int errors;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int cycles;

  // ---------------------------------------------------------------- clock and watchdog
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  // floor square root; the argument stays below 2^67 so 40 result bits suffice
  function automatic logic [63:0] floor_root(input wide_t s);
    wide_t res;
    wide_t c;
    res = '0;
    for (int b = 40; b >= 0; b--) begin
      c = res | (wide_t'(1) << b);
      if (c * c <= s) res = c;
    end
    return res[63:0];
  endfunction

  // round to nearest, ties away from zero, capped at 2^62
  function automatic longint div_nearest(input wide_t n, input wide_t d);
    wide_t q;
    wide_t rem;
    if (d == 0) return 0;
    q = n / d;
    rem = n % d;
    if ((rem << 1) >= d) q = q + 1;
    if (q >= (wide_t'(1) << 62)) return longint'(64'd1 << 62);
    return longint'(q[63:0]);
  endfunction

  // center plus the signed sum of two magnitudes over s, saturated
  function automatic logic signed [CW-1:0] tangent_coord(input longint c,
      input bit neg_a, input wide_t a, input bit neg_b, input wide_t b, input wide_t s);
    wide_t mag;
    bit neg;
    longint q;
    longint t;
    if (neg_a == neg_b) begin
      mag = a + b;
      neg = neg_a;
    end else if (a >= b) begin
      mag = a - b;
      neg = neg_a;
    end else begin
      mag = b - a;
      neg = neg_b;
    end
    q = div_nearest(mag, s);
    t = neg ? c - q : c + q;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[CW-1:0];
  endfunction

  function automatic tangents_t predict_tangents(input query_t q);
    tangents_t o;
    longint cx, cy, px, py, vx, vy;
    bit sx, sy;
    wide_t ax, ay, s, r, r2, rl, leg, a, b, c, e;
    logic [63:0] d;
    logic [63:0] gap;
    cx = q.cx; cy = q.cy; px = q.px; py = q.py;
    vx = px - cx;
    vy = py - cy;
    sx = vx < 0;
    sy = vy < 0;
    ax = wide_t'(sx ? -vx : vx);
    ay = wide_t'(sy ? -vy : vy);
    r = wide_t'(q.r);
    o = '{COUNT_NONE, '0, '0, '0, '0};
    s = ax * ax + ay * ay;
    d = floor_root(s);
    if (d + tol_model < r[63:0]) return o;
    gap = (d >= r[63:0]) ? d - r[63:0] : r[63:0] - d;
    if (gap <= tol_model) begin
      // on the circle: the point itself
      o.cnt = COUNT_ONE;
      o.fx = q.px;
      o.fy = q.py;
      return o;
    end
    r2 = r * r;
    leg = wide_t'(floor_root(s - r2));
    rl = r * leg;
    a = r2 * ax;
    b = rl * ay;
    c = r2 * ay;
    e = rl * ax;
    o.cnt = COUNT_TWO;
    o.fx = tangent_coord(cx, sx, a, !sy, b, s);
    o.fy = tangent_coord(cy, sy, c, sx, e, s);
    o.sx = tangent_coord(cx, sx, a, sy, b, s);
    o.sy = tangent_coord(cy, sy, c, !sx, e, s);
    return o;
  endfunction

  // ---------------------------------------------------------------- result side
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      // long hold-off so the pipe fills and the query side stalls
      hold_left <= HOLD_CYCLES;
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_left == HOLD_CYCLES) hold_req <= 1'b0;
  end

  function automatic void check_field(input string name, input logic [CW-1:0] exp_v,
                                      input logic [CW-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // values are stable between edges; a request taken at the next edge is checked here
  always @(negedge clk) begin
    tangents_t x;
    if (!rst && result.valid && result.ready) begin
      if (expected_tangents.size() == 0) begin
        $display("%0t: unexpected result request, count %0d", $time, result.tangent_count);
        errors++;
      end else begin
        x = expected_tangents.pop_front();
        check_field("tangent_count", CW'(x.cnt), CW'(result.tangent_count));
        check_field("first_x", x.fx, result.first_x);
        check_field("first_y", x.fy, result.first_y);
        check_field("second_x", x.sx, result.second_x);
        check_field("second_y", x.sy, result.second_y);
      end
    end
  end

  // ---------------------------------------------------------------- query side
  task automatic send_query(input query_t q, input bit typed, input tangents_t res);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      query.valid <= 1'b0;
      @(posedge clk);
    end
    query.valid <= 1'b1;
    query.center_x <= q.cx;
    query.center_y <= q.cy;
    query.radius <= q.r;
    query.point_x <= q.px;
    query.point_y <= q.py;
    // ready is settled at the falling edge, the request goes at the next rising edge
    do begin
      @(negedge clk);
      taken = query.ready;
      @(posedge clk);
    end while (!taken);
    expected_tangents.push_back(typed ? res : predict_tangents(q));
  endtask

  task automatic wait_idle(input int extra);
    query.valid <= 1'b0;
    while (expected_tangents.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_WIDTH-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_model = v;
  endtask

  function automatic logic signed [CW-1:0] rand_coord(input int shift);
    return $signed($urandom) >>> shift;
  endfunction

  // mostly circles with the point near, inside or outside, plus raw noise
  function automatic query_t random_query();
    query_t q;
    int mode;
    int sh;
    longint off;
    longint dv;
    mode = $urandom_range(0, 9);
    sh = $urandom_range(1, 20);
    q.cx = rand_coord($urandom_range(0, 24));
    q.cy = rand_coord($urandom_range(0, 24));
    q.r = (CW-1)'($urandom >> sh);
    if (mode < 2) begin
      q.cx = $urandom;
      q.cy = $urandom;
      q.r = (CW-1)'($urandom);
      q.px = $urandom;
      q.py = $urandom;
    end else if (mode < 5) begin
      // point anywhere around, often far outside
      q.px = q.cx + rand_coord($urandom_range(0, 20));
      q.py = q.cy + rand_coord($urandom_range(0, 20));
    end else if (mode < 8) begin
      // point on an axis near the circle, within a few tolerances of it
      dv = longint'($urandom_range(0, 4 * tol_model + 8)) - 2 * tol_model - 4;
      off = longint'(q.r) + dv;
      if ($urandom_range(0, 1)) off = -off;
      if ($urandom_range(0, 1)) begin
        q.px = CW'(q.cx + off);
        q.py = q.cy;
      end else begin
        q.px = q.cx;
        q.py = CW'(q.cy + off);
      end
    end else begin
      // point well inside a big circle
      q.r = (CW-1)'($urandom >> 2);
      q.px = q.cx + rand_coord(sh + 4);
      q.py = q.cy + rand_coord(sh + 4);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- directed table
  localparam tangents_t NO_RES = '{COUNT_NONE, '0, '0, '0, '0};
  localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
  localparam logic signed [CW-1:0] MINC = 32'sh80000000;
  localparam logic [CW-2:0] MAXR = 31'h7fffffff;

  row_t directed [] = '{
    // zero radius, point at center: one tangent, the point itself
    '{'{0, 0, 0, 0, 0}, 1, '{COUNT_ONE, 0, 0, 0, 0}},
    '{'{MINC, MINC, 0, MINC, MINC}, 1, '{COUNT_ONE, MINC, MINC, 0, 0}},
    // point at center of a real circle: inside
    '{'{100, -100, 1000, 100, -100}, 1, NO_RES},
    // just inside, on the edges of the tolerance band, just outside
    '{'{0, 0, 1000, 998, 0}, 1, NO_RES},
    '{'{0, 0, 1000, 999, 0}, 1, '{COUNT_ONE, 999, 0, 0, 0}},
    '{'{0, 0, 1000, 1000, 0}, 1, '{COUNT_ONE, 1000, 0, 0, 0}},
    '{'{0, 0, 1000, 0, -1001}, 1, '{COUNT_ONE, 0, -1001, 0, 0}},
    '{'{0, 0, 1000, 1002, 0}, 0, NO_RES},
    // two tangents in each quadrant
    '{'{0, 0, 65536, 131072, 131072}, 0, NO_RES},
    '{'{0, 0, 65536, -131072, 131072}, 0, NO_RES},
    '{'{0, 0, 65536, -131072, -131072}, 0, NO_RES},
    '{'{0, 0, 65536, 131072, -131072}, 0, NO_RES},
    // largest radius: point on the circle, then point at the center
    '{'{0, 0, MAXR, MAXC, 0}, 1, '{COUNT_ONE, MAXC, 0, 0, 0}},
    '{'{MINC, MINC, MAXR, MINC, MINC}, 1, NO_RES},
    // opposite corners, coordinate extremes, saturation
    '{'{MINC, MINC, 1, MAXC, MAXC}, 0, NO_RES},
    '{'{MAXC, MINC, 0, MINC, MAXC}, 0, NO_RES},
    '{'{MINC, MAXC, MAXR, MAXC, MINC}, 0, NO_RES},
    '{'{MAXC, MAXC, 65536, MINC, MINC}, 0, NO_RES},
    '{'{MAXC, 0, 3, MINC, 0}, 0, NO_RES},
    // tiny circle, point two units off the circle
    '{'{5, 5, 0, 7, 5}, 0, NO_RES},
    '{'{-7, 3, 1, -7, 6}, 0, NO_RES}
  };

  // ---------------------------------------------------------------- main sequence
  initial begin
    int tol_list[5];
    int idle_list[5];
    int stall_list[5];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    query.valid = 1'b0;
    query.center_x = '0;
    query.center_y = '0;
    query.radius = '0;
    query.point_x = '0;
    query.point_y = '0;
    tol_model = TOL_RESET;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run with the reset tolerance
    foreach (directed[i]) send_query(directed[i].q, directed[i].typed, directed[i].res);
    wait_idle(DRAIN_CYCLES);

    tol_list = '{0, 65535, $urandom_range(2, 65534), 40, 1};
    idle_list = '{0, 54, 0, 6, 0};
    stall_list = '{0, 0, 54, 6, 0};
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(TOL_WIDTH'(tol_list[ph]));
      idle_pct = idle_list[ph];
      stall_pct = stall_list[ph];
      if (ph == 4) hold_req = 1'b1;   // last phase starts under a long hold-off
      for (int n = 0; n < 380; n++) send_query(random_query(), 0, NO_RES);
      wait_idle(DRAIN_CYCLES);
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
